### src/multichannel_moving_median_top_assert.svh
// Assertion macros used by the moving median controller.
`ifndef MULTICHANNEL_MOVING_MEDIAN_TOP_ASSERT_SVH
`define MULTICHANNEL_MOVING_MEDIAN_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mmm_pkg.sv
// Constants, codes and controller/datapath interface types of the moving median filter.
package mmm_pkg;

    localparam int CHANNELS    = 32;
    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 32;

    // Fixed widths of the request and result fields.
    localparam int CH_BITS   = 6;
    localparam int WID_BITS  = 5;
    localparam int DATA_BITS = 32;
    localparam int STS_BITS  = 2;

    localparam int STORE_DEPTH = CHANNELS * WINDOW;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W       = $clog2(WINDOW);
    localparam int CMP_W       = (POS_W + 1 > WID_BITS) ? POS_W + 1 : WID_BITS;

    // The widest window in use is limited both by WINDOW and by the width field.
    localparam int WID_MAX    = (1 << WID_BITS) - 1;
    localparam int SORT_DEPTH = (WINDOW - 1 < WID_MAX) ? WINDOW - 1 : WID_MAX;
    localparam int SIDX_W     = (SORT_DEPTH > 1) ? $clog2(SORT_DEPTH) : 1;

    localparam logic [STS_BITS-1:0] ST_MEDIAN = 2'd0;
    localparam logic [STS_BITS-1:0] ST_BYPASS = 2'd1;
    localparam logic [STS_BITS-1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic start;
        logic rd_issue;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_bypass;
        logic is_range;
        logic rd_last;
        logic clr_last;
    } t_sts;

endpackage

### src/mmm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mmm_ctrl.sv
// Controller state machine of the moving median filter.
`include "multichannel_moving_median_top_assert.svh"

module mmm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  mmm_pkg::t_sts i_sts,
    output mmm_pkg::t_cmd o_cmd
);

    import mmm_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_START = 6'b000100,
        S_READ  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clear_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_bypass || i_sts.is_range) begin
                    n_state = S_DONE;
                end else begin
                    w_cmd.start = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                w_cmd.rd_issue = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last slot read is sorted in during this cycle.
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = w_cmd;

    `MMM_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == S_START, "accepted request did not start")
    `MMM_ASSERT_NEXT(a_start_reads, w_cmd.start, r_state == S_READ, "window read did not follow start")
    `MMM_ASSERT_SAME(a_read_in_range, w_cmd.rd_issue, !i_sts.is_bypass && !i_sts.is_range, "window read for bypass or out of range request")

endmodule

### src/mmm_dp.sv
// Datapath of the moving median filter: request registers, sample store and insertion sorter.
module mmm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmm_pkg::t_cmd                       i_cmd,
    output mmm_pkg::t_sts                       o_sts,
    input  logic [mmm_pkg::CH_BITS-1:0]         i_channel,
    input  logic [mmm_pkg::WID_BITS-1:0]        i_window_width,
    input  logic signed [mmm_pkg::DATA_BITS-1:0] i_sample,
    output logic signed [mmm_pkg::DATA_BITS-1:0] o_median_value,
    output logic [mmm_pkg::STS_BITS-1:0]        o_status
);

    import mmm_pkg::*;

    logic [CH_BITS-1:0]     r_ch;
    logic [WID_BITS-1:0]    r_wid;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic [ADDR_W-1:0]      r_base;
    logic [POS_W-1:0]       r_rd_idx;
    logic                   r_ins;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic [POS_W-1:0]       r_wpos [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_sorted [SORT_DEPTH];
    logic [SORT_DEPTH-1:0]  r_sv;
    logic [DATA_BITS-1:0]   r_med;
    logic [STS_BITS-1:0]    r_sts;

    logic                   w_bypass;
    logic                   w_range;
    logic [CH_W-1:0]        w_chi;
    logic [POS_W-1:0]       w_pos_cur;
    logic [CMP_W-1:0]       w_pos_inc;
    logic [POS_W-1:0]       w_pos_new;
    logic [ADDR_W-1:0]      w_base;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [SAMPLE_BITS-1:0] w_wdata;
    logic [ADDR_W-1:0]      w_raddr;
    logic [SAMPLE_BITS-1:0] w_rdata;
    logic [SORT_DEPTH-1:0]  w_gt;
    logic [SAMPLE_BITS-1:0] w_sorted_nx [SORT_DEPTH];
    logic [SORT_DEPTH-1:0]  w_sv_nx;
    logic [SIDX_W-1:0]      w_med_idx;

    assign w_bypass = (r_wid == '0);
    assign w_range  = !w_bypass && ((32'(r_ch) >= CHANNELS) || (32'(r_wid) >= WINDOW));

    // The write position advances and wraps once it reaches the window width,
    // which also catches a position left behind by an earlier, wider window.
    assign w_chi     = CH_W'(r_ch);
    assign w_pos_cur = r_wpos[w_chi];
    assign w_pos_inc = CMP_W'(w_pos_cur) + CMP_W'(1);
    assign w_pos_new = (w_pos_inc >= CMP_W'(r_wid)) ? '0 : POS_W'(w_pos_inc);
    assign w_base    = ADDR_W'(32'(w_chi) * WINDOW);

    assign w_we    = i_cmd.clear_wr || i_cmd.start;
    assign w_waddr = i_cmd.clear_wr ? r_clr_addr : (w_base + ADDR_W'(w_pos_new));
    assign w_wdata = i_cmd.clear_wr ? '0 : r_smp;
    assign w_raddr = r_base + ADDR_W'(r_rd_idx);

    mmm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sorted insertion: every entry greater than the new value moves up one
    // place; empty entries count as greater than anything.
    always_comb begin
        for (int p = 0; p < SORT_DEPTH; p++) begin
            w_gt[p] = !r_sv[p] || ($signed(r_sorted[p]) > $signed(w_rdata));
        end
        for (int p = 0; p < SORT_DEPTH; p++) begin
            w_sorted_nx[p] = r_sorted[p];
            w_sv_nx[p]     = r_sv[p];
            if (w_gt[p]) begin
                if ((p > 0) && w_gt[(p > 0) ? p - 1 : 0]) begin
                    w_sorted_nx[p] = r_sorted[(p > 0) ? p - 1 : 0];
                    w_sv_nx[p]     = r_sv[(p > 0) ? p - 1 : 0];
                end else begin
                    w_sorted_nx[p] = w_rdata;
                    w_sv_nx[p]     = 1'b1;
                end
            end
        end
    end

    assign w_med_idx = SIDX_W'(r_wid >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins      <= 1'b0;
            r_clr_addr <= '0;
            r_sv       <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wpos[c] <= '0;
            end
        end else begin
            r_ins <= i_cmd.rd_issue;
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.start) begin
                r_wpos[w_chi] <= w_pos_new;
                r_sv          <= '0;
            end else if (r_ins) begin
                r_sv <= w_sv_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch  <= i_channel;
            r_wid <= i_window_width;
            r_smp <= SAMPLE_BITS'($unsigned(i_sample));
        end
        if (i_cmd.start) begin
            r_base   <= w_base;
            r_rd_idx <= '0;
        end else if (i_cmd.rd_issue) begin
            r_rd_idx <= r_rd_idx + POS_W'(1);
        end
        if (r_ins) begin
            for (int p = 0; p < SORT_DEPTH; p++) begin
                r_sorted[p] <= w_sorted_nx[p];
            end
        end
        if (i_cmd.load_out) begin
            if (w_bypass) begin
                r_med <= DATA_BITS'(r_smp);
                r_sts <= ST_BYPASS;
            end else if (w_range) begin
                r_med <= '0;
                r_sts <= ST_RANGE;
            end else begin
                r_med <= DATA_BITS'(r_sorted[w_med_idx]);
                r_sts <= ST_MEDIAN;
            end
        end
    end

    assign o_sts.is_bypass = w_bypass;
    assign o_sts.is_range  = w_range;
    assign o_sts.rd_last   = ((CMP_W'(r_rd_idx) + CMP_W'(1)) == CMP_W'(r_wid));
    assign o_sts.clr_last  = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));

    assign o_median_value = r_med;
    assign o_status       = r_sts;

endmodule

### src/multichannel_moving_median_top.sv
// Top level of the multichannel moving median filter.
// Each request carries a channel, a window width and a sample and yields one
// result. A median request passes through the start, read, drain and done
// states; its reads go through the sample store's single read port, which
// delivers one window slot per cycle to the insertion sorter. A bypass or out
// of range request skips the reads and goes from the start state to done. In
// done the result register is loaded as soon as it is free, and the controller
// then returns to idle for the next request. A new request is taken while the
// previous result still waits in the output register; its own result then
// waits until that register has been read. After reset the sample store is
// cleared, all CHANNELS * WINDOW slots (512 by default), and no request is
// accepted until the clear is done.
module multichannel_moving_median_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mmm_pkg::CH_BITS-1:0]         i_channel,
    input  logic [mmm_pkg::WID_BITS-1:0]        i_window_width,
    input  logic signed [mmm_pkg::DATA_BITS-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mmm_pkg::DATA_BITS-1:0] o_median_value,
    output logic [mmm_pkg::STS_BITS-1:0]        o_status
);

    import mmm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    mmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mmm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_channel      (i_channel),
        .i_window_width (i_window_width),
        .i_sample       (i_sample),
        .o_median_value (o_median_value),
        .o_status       (o_status)
    );

endmodule

### sim/tb_top.sv
// Self-checking testbench of the multichannel moving median filter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mmm_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 50;
    localparam int PHASE_ITEMS  = 430;

    typedef struct packed {
        logic [CH_BITS-1:0]          ch;
        logic [WID_BITS-1:0]         wid;
        logic signed [DATA_BITS-1:0] smp;
    } t_request;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] value;
        logic [STS_BITS-1:0]         status;
    } t_median_res;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic [CH_BITS-1:0]          i_channel      = '0;
    logic [WID_BITS-1:0]         i_window_width = '0;
    logic signed [DATA_BITS-1:0] i_sample       = '0;
    logic                        i_out_ready    = 1'b0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic signed [DATA_BITS-1:0] o_median_value;
    logic [STS_BITS-1:0]         o_status;

    t_request    request_q[$];
    t_median_res median_due_q[$];

    // Own copy of the per-channel sample rings and write positions.
    logic signed [DATA_BITS-1:0] ring_mem [CHANNELS][WINDOW];
    int                          ring_pos [CHANNELS];

    int          send_idle_pct = 0;
    int          out_stall_pct = 0;
    int          fail_count    = 0;
    int unsigned cycle_count   = 0;

    multichannel_moving_median_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_channel      (i_channel),
        .i_window_width (i_window_width),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_median_value (o_median_value),
        .o_status       (o_status)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    task automatic predict_median(input t_request r);
        t_median_res                 res;
        logic signed [DATA_BITS-1:0] win [WINDOW];
        logic signed [DATA_BITS-1:0] tmp;
        int                          n;
        int                          pos;
        if (r.wid == 0) begin
            res.value  = r.smp;
            res.status = ST_BYPASS;
        end else if (r.ch >= CHANNELS || r.wid >= WINDOW) begin
            res.value  = '0;
            res.status = ST_RANGE;
        end else begin
            n   = int'(r.wid);
            // A position left over from a wider window wraps straight to zero.
            pos = ring_pos[r.ch] + 1;
            if (pos >= n) pos = 0;
            ring_pos[r.ch]      = pos;
            ring_mem[r.ch][pos] = r.smp;
            for (int i = 0; i < n; i++) win[i] = ring_mem[r.ch][i];
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n - 1 - i; j++) begin
                    if (win[j] > win[j+1]) begin
                        tmp      = win[j];
                        win[j]   = win[j+1];
                        win[j+1] = tmp;
                    end
                end
            end
            res.value  = win[n/2];
            res.status = ST_MEDIAN;
        end
        median_due_q.push_back(res);
    endtask

    // Driver: predicts each accepted request and presents the next one.
    always @(posedge i_clk) begin : driver
        t_request taken;
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                taken.ch  = i_channel;
                taken.wid = i_window_width;
                taken.smp = i_sample;
                predict_median(taken);
            end
            if (i_in_valid && !o_in_ready) begin
                // Hold the request until it is taken.
            end else if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = request_q.pop_front();
                i_channel      <= nxt.ch;
                i_window_width <= nxt.wid;
                i_sample       <= nxt.smp;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result with the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_median_res due;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (median_due_q.size() == 0) begin
                    $display("%0t: unexpected result, value %0d status %0d",
                             $time, o_median_value, o_status);
                    fail_count++;
                end else begin
                    due = median_due_q.pop_front();
                    if (o_median_value !== due.value) begin
                        $display("%0t: median_value expected %0d actual %0d",
                                 $time, due.value, o_median_value);
                        fail_count++;
                    end
                    if (o_status !== due.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, due.status, o_status);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic add_request(input int ch, input int wid, input logic [DATA_BITS-1:0] smp);
        t_request r;
        r.ch  = CH_BITS'(ch);
        r.wid = WID_BITS'(wid);
        r.smp = smp;
        request_q.push_back(r);
    endtask

    function automatic logic [DATA_BITS-1:0] pick_sample();
        logic [DATA_BITS-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $signed($urandom_range(7)) - 4;
            2: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $signed($urandom_range(1000)) - 500;
        endcase
        return v;
    endfunction

    // Mostly bursts on one channel with a steady width so that the rings fill,
    // with the odd request of arbitrary fields mixed in.
    task automatic add_random_requests(input int count);
        int left;
        int len;
        int ch;
        int wid;
        left = count;
        while (left > 0) begin
            if ($urandom_range(99) < 80) begin
                ch  = $urandom_range(CHANNELS - 1);
                wid = $urandom_range(WINDOW - 1, 1);
                len = $urandom_range(2 * WINDOW, 1);
                repeat (len) begin
                    add_request(ch, wid, pick_sample());
                    left--;
                end
            end else begin
                add_request($urandom_range(63), $urandom_range(31), $urandom);
                left--;
            end
        end
    endtask

    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || median_due_q.size() != 0);
    endtask

    initial begin : timeout
        wait (cycle_count >= CYCLE_LIMIT);
        $display("multichannel_moving_median_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        for (int c = 0; c < CHANNELS; c++) begin
            ring_pos[c] = 0;
            for (int s = 0; s < WINDOW; s++) ring_mem[c][s] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: bypass, out of range and median cases.
        add_request(0, 0, 32'h7fff_ffff);
        add_request(63, 0, 32'h8000_0000);
        add_request(31, 0, 32'hffff_ffff);
        add_request(32, 5, 1);
        add_request(63, 31, 32'hffff_ffff);
        add_request(0, WINDOW, 5);
        add_request(31, 31, 7);
        add_request(0, 1, 32'h8000_0000);
        add_request(0, 1, 32'h7fff_ffff);
        // Widest window while most slots still hold zero from reset.
        add_request(31, WINDOW - 1, 32'h7fff_ffff);
        add_request(31, WINDOW - 1, 32'h8000_0000);
        // Narrower width than the stored position leaves.
        add_request(31, 2, 3);
        repeat (4) add_request(5, 4, 9);
        add_request(7, 2, 32'hffff_fffd);
        add_request(7, 2, 8);
        add_request(1, WINDOW - 1, 100);
        add_request(1, WINDOW - 1, 32'hffff_ff9c);
        add_request(1, WINDOW - 1, 50);
        add_request(1, WINDOW - 1, 32'hffff_ffce);
        add_request(1, WINDOW - 1, 0);
        add_request(1, WINDOW - 1, 32'h7fff_ffff);
        add_request(1, WINDOW - 1, 32'h8000_0000);
        wait_for_drain();

        // Random phases; each ends with the sender held off until all is back.
        send_idle_pct = 0;
        out_stall_pct = 0;
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        send_idle_pct = 65;
        out_stall_pct = 0;
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        send_idle_pct = 0;
        out_stall_pct = 65;
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        send_idle_pct = 14;
        out_stall_pct = 14;
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        out_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && median_due_q.size() == 0) begin
            $display("multichannel_moving_median_top regression: pass");
        end else begin
            $display("multichannel_moving_median_top regression: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/mmm_pkg.sv
src/mmm_ram.sv
src/mmm_ctrl.sv
src/mmm_dp.sv
src/multichannel_moving_median_top.sv
sim/tb_top.sv
